// ===== rtl/core/swcr_pkg.sv =====
// Package for the sensor word-pair CRC receiver.
// Holds the result codes, frame byte positions, result struct and CRC-8 step.
// No dependencies.
`default_nettype none

package swcr_pkg;

  // CRC-8, polynomial 0x31, seeded with 0xFF, MSB first, no final XOR
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // Reset values of the stored readings
  localparam logic [15:0] ECO2_RESET = 16'd400;
  localparam logic [15:0] TVOC_RESET = 16'd0;

  // Request kinds on the input side
  localparam logic CMD_DATA  = 1'b0;
  localparam logic CMD_ABORT = 1'b1;

  // Position of the next byte within the six-byte reply
  localparam logic [2:0] POS_FIRST_HI   = 3'd0;
  localparam logic [2:0] POS_FIRST_LO   = 3'd1;
  localparam logic [2:0] POS_FIRST_CRC  = 3'd2;
  localparam logic [2:0] POS_SECOND_HI  = 3'd3;
  localparam logic [2:0] POS_SECOND_LO  = 3'd4;
  localparam logic [2:0] POS_SECOND_CRC = 3'd5;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_FIRST_BAD  = 2'd1,
    STATUS_SECOND_BAD = 2'd2,
    STATUS_ABORTED    = 2'd3
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] eco2;
    logic [15:0] tvoc;
  } result_t;

  // Fold one byte into the running CRC, one bit per step
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/swcr_frame.sv =====
// Frame tracker: byte position, running CRC, staged words and stored readings.
// Depends on swcr_pkg for codes, the result struct and the CRC step.
`default_nettype none

module swcr_frame (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              take,
  input  wire logic              command,
  input  wire logic [7:0]        rx_byte,
  output logic                   res_valid,
  output swcr_pkg::result_t      res
);

  logic [2:0]  byte_position, byte_position_next;
  logic [7:0]  running_crc, running_crc_next;
  logic [15:0] staged_first_word, staged_first_word_next;
  logic [15:0] staged_second_word, staged_second_word_next;
  logic        first_word_good, first_word_good_next;
  logic [15:0] stored_eco2, stored_eco2_next;
  logic [15:0] stored_tvoc, stored_tvoc_next;
  logic [7:0]  crc_step;
  swcr_pkg::status_t status;

  assign crc_step = swcr_pkg::crc8_byte(running_crc, rx_byte);

  // Advance the frame by one request
  always_comb begin
    byte_position_next      = byte_position;
    running_crc_next        = running_crc;
    staged_first_word_next  = staged_first_word;
    staged_second_word_next = staged_second_word;
    first_word_good_next    = first_word_good;
    stored_eco2_next        = stored_eco2;
    stored_tvoc_next        = stored_tvoc;
    res_valid               = 1'b0;
    status                  = swcr_pkg::STATUS_OK;
    if (take) begin
      if (command == swcr_pkg::CMD_ABORT) begin
        byte_position_next   = swcr_pkg::POS_FIRST_HI;
        running_crc_next     = swcr_pkg::CRC_INIT;
        first_word_good_next = 1'b0;
        res_valid            = 1'b1;
        status               = swcr_pkg::STATUS_ABORTED;
      end else begin
        case (byte_position)
          swcr_pkg::POS_FIRST_HI: begin
            staged_first_word_next = {rx_byte, 8'h00};
            running_crc_next       = crc_step;
            byte_position_next     = swcr_pkg::POS_FIRST_LO;
          end
          swcr_pkg::POS_FIRST_LO: begin
            staged_first_word_next = {staged_first_word[15:8], rx_byte};
            running_crc_next       = crc_step;
            byte_position_next     = swcr_pkg::POS_FIRST_CRC;
          end
          swcr_pkg::POS_FIRST_CRC: begin
            first_word_good_next = (running_crc == rx_byte);
            running_crc_next     = swcr_pkg::CRC_INIT;
            byte_position_next   = swcr_pkg::POS_SECOND_HI;
          end
          swcr_pkg::POS_SECOND_HI: begin
            staged_second_word_next = {rx_byte, 8'h00};
            running_crc_next        = crc_step;
            byte_position_next      = swcr_pkg::POS_SECOND_LO;
          end
          swcr_pkg::POS_SECOND_LO: begin
            staged_second_word_next = {staged_second_word[15:8], rx_byte};
            running_crc_next        = crc_step;
            byte_position_next      = swcr_pkg::POS_SECOND_CRC;
          end
          default: begin
            // last byte of the reply: check and commit both readings together
            if (!first_word_good) begin
              status = swcr_pkg::STATUS_FIRST_BAD;
            end else if (running_crc != rx_byte) begin
              status = swcr_pkg::STATUS_SECOND_BAD;
            end else begin
              stored_eco2_next = staged_first_word;
              stored_tvoc_next = staged_second_word;
              status           = swcr_pkg::STATUS_OK;
            end
            byte_position_next   = swcr_pkg::POS_FIRST_HI;
            running_crc_next     = swcr_pkg::CRC_INIT;
            first_word_good_next = 1'b0;
            res_valid            = 1'b1;
          end
        endcase
      end
    end
  end

  // Result shows the readings as they stand after this request
  always_comb begin
    res.status = status;
    res.eco2   = stored_eco2_next;
    res.tvoc   = stored_tvoc_next;
  end

  // Hold frame state and readings
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position      <= swcr_pkg::POS_FIRST_HI;
      running_crc        <= swcr_pkg::CRC_INIT;
      staged_first_word  <= '0;
      staged_second_word <= '0;
      first_word_good    <= 1'b0;
      stored_eco2        <= swcr_pkg::ECO2_RESET;
      stored_tvoc        <= swcr_pkg::TVOC_RESET;
    end else begin
      byte_position      <= byte_position_next;
      running_crc        <= running_crc_next;
      staged_first_word  <= staged_first_word_next;
      staged_second_word <= staged_second_word_next;
      first_word_good    <= first_word_good_next;
      stored_eco2        <= stored_eco2_next;
      stored_tvoc        <= stored_tvoc_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/swcr_out_reg.sv =====
// Result register on the master side of the receiver.
// Depends on swcr_pkg for the result struct.
`default_nettype none

module swcr_out_reg (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,
  input  wire swcr_pkg::result_t  res,
  output logic                    free,
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [31:0]             m_axis_tdata,  // eco2 [15:0], tvoc [31:16]
  output logic [1:0]              m_axis_tuser   // status [1:0]
);

  logic valid;
  swcr_pkg::result_t held;

  // Slot can take a new result when empty or being drained this cycle
  assign free = !valid || m_axis_tready;

  // Valid flag: set on load, drop once the request is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (m_axis_tready) begin
      valid <= 1'b0;
    end
  end

  // Payload: capture on load only
  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign m_axis_tvalid = valid;
  assign m_axis_tdata  = {held.tvoc, held.eco2};
  assign m_axis_tuser  = held.status;

endmodule

`default_nettype wire

// ===== rtl/core/sensor_word_pair_crc_receiver.sv =====
// Top level of the sensor word-pair CRC receiver.
// Depends on swcr_pkg, swcr_frame and swcr_out_reg.
//
// Usage:
//   Slave side takes one reply byte per request: s_axis_tdata carries the
//   byte, s_axis_tuser is 0 for a data byte and 1 to abort the frame.
//   A reply is six bytes: first word high, low, CRC, second word high,
//   low, CRC. CRC-8 is polynomial 0x31, seed 0xFF, over each word.
//   Master side gives one request after the sixth byte and after every
//   abort: m_axis_tuser is the status (0 ok, 1 first CRC bad, 2 second CRC
//   bad, 3 aborted), m_axis_tdata the stored readings eco2 and tvoc.
//   Readings change only when both CRCs match.
// Path: a result reaches the master side through the input register, then
//   the result register, after the byte that causes it is accepted; a
//   stalled result register can hold it back in the input register.
// Throughput: one byte per cycle unless the master side stalls; the CRC
//   of a byte is eight unrolled XOR steps, input register to frame state.
// Reset: readings become 400 and 0, the frame restarts at its first byte,
//   both pipeline registers empty.
// Stall: the result register holds its request while m_axis_tready is low;
//   the input register then fills and s_axis_tready drops.
`default_nettype none

module sensor_word_pair_crc_receiver (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // rx_byte [7:0]
  input  wire logic        s_axis_tuser,   // command [0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // eco2 [15:0], tvoc [31:16]
  output logic [1:0]       m_axis_tuser    // status [1:0]
);

  logic       in_valid;
  logic       in_command;
  logic [7:0] in_byte;
  logic       out_free;
  logic       advance;
  logic       res_valid;
  swcr_pkg::result_t res;

  // Move the held byte on when the result slot can take what it causes
  assign advance       = in_valid && out_free;
  assign s_axis_tready = !in_valid || advance;

  // Input register: valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  // Input register: payload
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_command <= s_axis_tuser;
      in_byte    <= s_axis_tdata;
    end
  end

  swcr_frame u_frame (
    .clk       (clk),
    .rst       (rst),
    .take      (advance),
    .command   (in_command),
    .rx_byte   (in_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  swcr_out_reg u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (advance && res_valid),
    .res           (res),
    .free          (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire

// ===== rtl/core/swcr_checker.sv =====
// Port-level checker for the sensor word-pair CRC receiver, bound to the top.
// Depends on swcr_pkg for status codes and reset readings.
`default_nettype none

module swcr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);

  logic [31:0] last_data;

  // Track the readings shown by the last delivered request
  always_ff @(posedge clk) begin
    if (rst) begin
      last_data <= {swcr_pkg::TVOC_RESET, swcr_pkg::ECO2_RESET};
    end else if (m_axis_tvalid && m_axis_tready) begin
      last_data <= m_axis_tdata;
    end
  end

  // A stalled result holds its payload
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // Nothing comes out right after reset
  assert property (@(posedge clk) disable iff (rst) $past(rst) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

  // Failed or aborted frames leave the readings as they were
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != swcr_pkg::STATUS_OK) |-> m_axis_tdata == last_data)
    else $error("readings changed without a good frame");

  // With both sides empty and no request offered, the slave side is ready
  assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && !$past(s_axis_tvalid) && !$past(m_axis_tvalid) && !m_axis_tvalid
      |-> s_axis_tready)
    else $error("input not ready while idle");

endmodule

bind sensor_word_pair_crc_receiver swcr_checker u_swcr_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== tb/sv/sensor_word_pair_crc_receiver_tb.sv =====
// Testbench for the sensor word-pair CRC receiver.
// Streams six-byte sensor replies and aborts into the block and checks each status and
// reading pair against a CRC-8 frame tracker kept here. Depends on swcr_pkg and the RTL.
`default_nettype none

module sensor_word_pair_crc_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // rx_byte [7:0]
  logic        s_axis_tuser = swcr_pkg::CMD_DATA; // command [0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;           // eco2 [15:0], tvoc [31:16]
  logic [1:0]  m_axis_tuser;           // status [1:0]

  // Frame tracker state
  logic [2:0]  frame_pos = swcr_pkg::POS_FIRST_HI;
  logic [7:0]  word_crc = swcr_pkg::CRC_INIT;
  logic [15:0] staged_eco2 = 16'h0000;
  logic [15:0] staged_tvoc = 16'h0000;
  logic        first_ok = 1'b0;
  logic [15:0] eco2_now = swcr_pkg::ECO2_RESET;
  logic [15:0] tvoc_now = swcr_pkg::TVOC_RESET;

  swcr_pkg::result_t due_reports[$];
  int          mismatches = 0;
  int          requests_sent = 0;
  bit          sender_gaps = 1'b0;
  bit          receiver_gaps = 1'b0;
  bit          offering = 1'b0;
  int          stall_cycles = 0;

  sensor_word_pair_crc_receiver dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Bit-serial CRC-8 update, feeding data bits MSB first into the feedback
  function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] din);
    logic [7:0] r;
    logic       fb;
    r = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[7] ^ din[i];
      r  = {r[6:0], 1'b0} ^ (fb ? swcr_pkg::CRC_POLY : 8'h00);
    end
    return r;
  endfunction

  // Advance the tracker by one accepted request and queue the report it causes
  task automatic follow_reply_byte(input logic cmd, input logic [7:0] data);
    swcr_pkg::result_t rpt;
    if (cmd == swcr_pkg::CMD_ABORT) begin
      frame_pos = swcr_pkg::POS_FIRST_HI;
      word_crc  = swcr_pkg::CRC_INIT;
      first_ok  = 1'b0;
      rpt.status = swcr_pkg::STATUS_ABORTED;
      rpt.eco2   = eco2_now;
      rpt.tvoc   = tvoc_now;
      due_reports.push_back(rpt);
    end else begin
      case (frame_pos)
        swcr_pkg::POS_FIRST_HI: begin
          staged_eco2 = {data, 8'h00};
          word_crc    = crc8_step(word_crc, data);
          frame_pos   = swcr_pkg::POS_FIRST_LO;
        end
        swcr_pkg::POS_FIRST_LO: begin
          staged_eco2[7:0] = data;
          word_crc         = crc8_step(word_crc, data);
          frame_pos        = swcr_pkg::POS_FIRST_CRC;
        end
        swcr_pkg::POS_FIRST_CRC: begin
          first_ok  = (word_crc == data);
          word_crc  = swcr_pkg::CRC_INIT;
          frame_pos = swcr_pkg::POS_SECOND_HI;
        end
        swcr_pkg::POS_SECOND_HI: begin
          staged_tvoc = {data, 8'h00};
          word_crc    = crc8_step(word_crc, data);
          frame_pos   = swcr_pkg::POS_SECOND_LO;
        end
        swcr_pkg::POS_SECOND_LO: begin
          staged_tvoc[7:0] = data;
          word_crc         = crc8_step(word_crc, data);
          frame_pos        = swcr_pkg::POS_SECOND_CRC;
        end
        default: begin
          // Last byte: the first word's verdict wins over the second's
          if (!first_ok) begin
            rpt.status = swcr_pkg::STATUS_FIRST_BAD;
          end else if (word_crc != data) begin
            rpt.status = swcr_pkg::STATUS_SECOND_BAD;
          end else begin
            eco2_now   = staged_eco2;
            tvoc_now   = staged_tvoc;
            rpt.status = swcr_pkg::STATUS_OK;
          end
          rpt.eco2 = eco2_now;
          rpt.tvoc = tvoc_now;
          due_reports.push_back(rpt);
          frame_pos = swcr_pkg::POS_FIRST_HI;
          word_crc  = swcr_pkg::CRC_INIT;
          first_ok  = 1'b0;
        end
      endcase
    end
  endtask

  // Offer one request from a falling edge; return at the falling edge after acceptance
  task automatic send_request(input logic cmd, input logic [7:0] data);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      if (offering) s_axis_tvalid <= 1'b0;
      offering = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= data;
    offering = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    follow_reply_byte(cmd, data);
    requests_sent++;
    @(negedge clk);
  endtask

  // Drop valid at the current falling edge
  task automatic go_quiet;
    if (offering) s_axis_tvalid <= 1'b0;
    offering = 1'b0;
  endtask

  // Hold the sender until every queued report has come out
  task automatic await_all_reports;
    go_quiet();
    wait (due_reports.size() == 0);
    @(negedge clk);
  endtask

  // Send a reply; flip masks corrupt the CRC bytes, cut_at < 6 aborts at that byte
  task automatic send_frame(input logic [15:0] w1, input logic [15:0] w2,
                            input logic [7:0] flip1, input logic [7:0] flip2,
                            input int cut_at);
    logic [7:0] reply [6];
    reply[0] = w1[15:8];
    reply[1] = w1[7:0];
    reply[2] = crc8_step(crc8_step(swcr_pkg::CRC_INIT, w1[15:8]), w1[7:0]) ^ flip1;
    reply[3] = w2[15:8];
    reply[4] = w2[7:0];
    reply[5] = crc8_step(crc8_step(swcr_pkg::CRC_INIT, w2[15:8]), w2[7:0]) ^ flip2;
    for (int k = 0; k < 6 && k < cut_at; k++) send_request(swcr_pkg::CMD_DATA, reply[k]);
    if (cut_at < 6) send_request(swcr_pkg::CMD_ABORT, 8'($urandom_range(0, 255)));
  endtask

  // Readings lean toward the all-zero and all-one extremes
  function automatic logic [15:0] pick_word;
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [7:0] pick_flip;
    return 8'($urandom_range(1, 255));
  endfunction

  // Mostly well-formed replies with random content, plus corrupt, cut and stray traffic
  task automatic run_traffic(input int goal, input bit mixed);
    int kind;
    while (requests_sent < goal) begin
      if (mixed && $urandom_range(0, 15) == 0) begin
        sender_gaps   = 1'($urandom_range(0, 1));
        receiver_gaps = 1'($urandom_range(0, 1));
      end
      kind = int'($urandom_range(0, 99));
      if (kind < 60) begin
        send_frame(pick_word(), pick_word(), 8'h00, 8'h00, 6);
      end else if (kind < 70) begin
        send_frame(pick_word(), pick_word(), pick_flip(),
                   $urandom_range(0, 1) ? pick_flip() : 8'h00, 6);
      end else if (kind < 80) begin
        send_frame(pick_word(), pick_word(), 8'h00, pick_flip(), 6);
      end else if (kind < 92) begin
        send_frame(pick_word(), pick_word(), 8'h00, 8'h00, int'($urandom_range(0, 5)));
      end else begin
        repeat ($urandom_range(1, 7))
          send_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        send_request(swcr_pkg::CMD_ABORT, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic test_abort_after_reset;
    send_request(swcr_pkg::CMD_ABORT, 8'hA5);
  endtask

  task automatic test_extreme_readings;
    send_frame(16'hFFFF, 16'h0000, 8'h00, 8'h00, 6);
    send_frame(16'h0000, 16'hFFFF, 8'h00, 8'h00, 6);
  endtask

  task automatic test_crc_mismatch;
    // First word bad while the second would pass, then the second word bad alone
    send_frame(16'h1234, 16'hBEEF, 8'h01, 8'h00, 6);
    send_frame(16'h8001, 16'h7FFE, 8'h00, 8'h80, 6);
  endtask

  task automatic test_random_frames;
    sender_gaps   = 1'b1;
    receiver_gaps = 1'b1;
    run_traffic(1400, 1'b1);
  endtask

  task automatic test_output_backpressure;
    sender_gaps   = 1'b0;
    receiver_gaps = 1'b0;
    stall_cycles  = 80;
    repeat (4) begin
      send_frame(pick_word(), pick_word(), 8'h00, 8'h00, 6);
      repeat (3) send_request(swcr_pkg::CMD_ABORT, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_pause_until_drained;
    sender_gaps   = 1'b1;
    receiver_gaps = 1'b1;
    repeat (3) begin
      send_frame(pick_word(), pick_word(), 8'h00, 8'h00, 6);
      await_all_reports();
    end
  endtask

  task automatic test_full_rate;
    sender_gaps   = 1'b0;
    receiver_gaps = 1'b0;
    run_traffic(1850, 1'b0);
  endtask

  // Receiver side: long stall on request, otherwise short random holds if gaps are on
  always begin
    @(negedge clk);
    if (stall_cycles > 0) begin
      m_axis_tready <= 1'b0;
      repeat (stall_cycles) @(negedge clk);
      stall_cycles = 0;
      m_axis_tready <= 1'b1;
    end else if (receiver_gaps && $urandom_range(0, 3) == 0) begin
      m_axis_tready <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each accepted report with the oldest queued one
  always @(posedge clk) begin
    swcr_pkg::result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (due_reports.size() == 0) begin
        $display("%0t: unexpected report, expected none, got status %0d eco2 %0d tvoc %0d",
                 $time, m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16]);
        mismatches++;
      end else begin
        want = due_reports.pop_front();
        if (m_axis_tuser !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, m_axis_tuser);
          mismatches++;
        end
        if (m_axis_tdata[15:0] !== want.eco2) begin
          $display("%0t: eco2 expected %0d got %0d", $time, want.eco2, m_axis_tdata[15:0]);
          mismatches++;
        end
        if (m_axis_tdata[31:16] !== want.tvoc) begin
          $display("%0t: tvoc expected %0d got %0d", $time, want.tvoc, m_axis_tdata[31:16]);
          mismatches++;
        end
      end
    end
  end

  // Bound the run
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_abort_after_reset();
    test_extreme_readings();
    test_crc_mismatch();
    test_random_frames();
    test_output_backpressure();
    test_pause_until_drained();
    test_full_rate();

    // Drain, then allow for the two-stage pipeline
    go_quiet();
    for (int c = 0; c < 5000 && due_reports.size() != 0; c++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (due_reports.size() != 0) begin
      $display("%0t: %0d reports expected but never arrived", $time, due_reports.size());
      mismatches += due_reports.size();
    end

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
